// ===== rtl/core/msp_pkg.sv =====
// Package for the multi-motor step positioner.
// Holds operation, response, status and register codes, the motor state type
// and the reset constants. It depends on nothing.
package msp_pkg;

  // Number of motors and the widths derived from it.
  localparam int MOTOR_COUNT = 3;
  localparam int MSEL_W      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  // Field widths fixed by the interface.
  localparam int OP_W      = 3;
  localparam int INDEX_W   = 3;
  localparam int POS_W     = 32;
  localparam int ELAPSED_W = 16;
  localparam int RATE_W    = 8;
  localparam int TRAVEL_W  = 31;
  localparam int LOAD_W    = 6;
  localparam int STEP_W    = ELAPSED_W + RATE_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Travel registers exist for three motors whatever the motor count.
  localparam int TRAVEL_COUNT = 3;

  localparam logic [LOAD_W-1:0] LOAD_MOVING = LOAD_W'(35);
  localparam logic [LOAD_W-1:0] LOAD_IDLE   = '0;
  localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_TICK        = 3'd0,
    OP_HALT        = 3'd1,
    OP_SYNC        = 3'd2,
    OP_RAW_MOVE    = 3'd3,
    OP_GUARDED_MOVE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    RESP_OK        = 3'd0,
    RESP_NO_MOTOR  = 3'd1,
    RESP_NOT_CAL   = 3'd2,
    RESP_INVALID   = 3'd3,
    RESP_BUSY      = 3'd4
  } resp_e;

  typedef enum logic [1:0] {
    ST_UP     = 2'd0,
    ST_DOWN   = 2'd1,
    ST_HALTED = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEPS_PER_MS = 3'd0,
    CFG_TRAVEL0      = 3'd1,
    CFG_TRAVEL1      = 3'd2,
    CFG_TRAVEL2      = 3'd3
  } cfg_idx_e;

  // Stored state of one motor.
  typedef struct packed {
    status_e             status;
    logic [LOAD_W-1:0]   load;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    target;
  } motor_state_t;

  // Request as seen by one motor's update logic.
  typedef struct packed {
    op_e                 op;
    logic                addressed;
    logic [POS_W-1:0]    value;
    logic [STEP_W-1:0]   step;
  } motor_cmd_t;

  // Reset position of a motor; the target resets to the same value.
  function automatic logic [POS_W-1:0] reset_position(input int m);
    logic [POS_W-1:0] pos;
    unique case (m)
      1:       pos = POS_W'(0);
      default: pos = POS_W'(20000);
    endcase
    return pos;
  endfunction

  // Reset travel of a motor.
  function automatic logic [TRAVEL_W-1:0] reset_travel(input int m);
    logic [TRAVEL_W-1:0] tr;
    unique case (m)
      1:       tr = TRAVEL_W'(12000);
      default: tr = TRAVEL_W'(40000);
    endcase
    return tr;
  endfunction

endpackage

// ===== rtl/core/multi_motor_step_positioner.sv =====
// Top level of the multi-motor step positioner: request register, motor state,
// configuration registers and result register. Depends on msp_pkg and
// msp_motor_update.
//
//   channel   handshake                  payload
//   request   start_i, busy_o            operation_i, motor_index_i,
//                                        target_position_i, elapsed_ms_i
//   result    done_o (one-cycle strobe)  response_o, motor_status_o, motor_load_o,
//                                        motor_position_o, motor_target_o
//   config    cfg_valid_i, cfg_ready_o   cfg_index_i, cfg_data_i
//
// A request is registered with its step count (elapsed times rate) on the edge
// that accepts it; the motors update and the result is registered on the next
// edge. A new request is taken every cycle: busy_o stays low and cfg_ready_o
// stays high. Reset restores the power-up positions, targets, rate and travels;
// the receiver cannot stall.
module multi_motor_step_positioner (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [msp_pkg::OP_W-1:0]            operation_i,
  input  logic [msp_pkg::INDEX_W-1:0]         motor_index_i,
  input  logic signed [msp_pkg::POS_W-1:0]    target_position_i,
  input  logic [msp_pkg::ELAPSED_W-1:0]       elapsed_ms_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [msp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [msp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                done_o,
  output logic [2:0]                          response_o,
  output logic [1:0]                          motor_status_o,
  output logic [msp_pkg::LOAD_W-1:0]          motor_load_o,
  output logic signed [msp_pkg::POS_W-1:0]    motor_position_o,
  output logic signed [msp_pkg::POS_W-1:0]    motor_target_o
);

  // Configuration registers.
  logic [msp_pkg::RATE_W-1:0]   rate_q;
  logic [msp_pkg::TRAVEL_W-1:0] travel_q [msp_pkg::TRAVEL_COUNT];

  // Request register.
  logic                          req_valid_q;
  msp_pkg::op_e                  op_q;
  logic [msp_pkg::INDEX_W-1:0]   idx_q;
  logic [msp_pkg::POS_W-1:0]     value_q;
  logic [msp_pkg::STEP_W-1:0]    step_q;
  logic [msp_pkg::STEP_W-1:0]    step_d;

  // Motor state and its next value.
  msp_pkg::motor_state_t         state_q [msp_pkg::MOTOR_COUNT];
  msp_pkg::motor_state_t         state_d [msp_pkg::MOTOR_COUNT];
  msp_pkg::resp_e                motor_resp [msp_pkg::MOTOR_COUNT];

  // Result register.
  logic                          done_q;
  msp_pkg::resp_e                resp_q;
  msp_pkg::resp_e                resp_d;
  msp_pkg::motor_state_t         res_q;
  msp_pkg::motor_state_t         res_d;

  logic                          idx_valid;
  logic                          accept;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= msp_pkg::RATE_RESET;
      for (int m = 0; m < msp_pkg::TRAVEL_COUNT; m++) begin
        travel_q[m] <= msp_pkg::reset_travel(m);
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (msp_pkg::cfg_idx_e'(cfg_index_i))
        msp_pkg::CFG_STEPS_PER_MS: rate_q <= cfg_data_i[msp_pkg::RATE_W-1:0];
        msp_pkg::CFG_TRAVEL0:      travel_q[0] <= cfg_data_i[msp_pkg::TRAVEL_W-1:0];
        msp_pkg::CFG_TRAVEL1:      travel_q[1] <= cfg_data_i[msp_pkg::TRAVEL_W-1:0];
        msp_pkg::CFG_TRAVEL2:      travel_q[2] <= cfg_data_i[msp_pkg::TRAVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The step count is multiplied out as the request is registered.
  assign step_d = msp_pkg::STEP_W'(elapsed_ms_i) * msp_pkg::STEP_W'(rate_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= msp_pkg::op_e'(operation_i);
      idx_q   <= motor_index_i;
      value_q <= target_position_i;
      step_q  <= step_d;
    end
  end

  assign idx_valid = (idx_q < msp_pkg::INDEX_W'(msp_pkg::MOTOR_COUNT));

  // One update unit per motor.
  for (genvar m = 0; m < msp_pkg::MOTOR_COUNT; m++) begin : g_motor
    msp_pkg::motor_cmd_t cmd;

    assign cmd.op        = op_q;
    assign cmd.addressed = (idx_q == msp_pkg::INDEX_W'(m));
    assign cmd.value     = value_q;
    assign cmd.step      = step_q;

    msp_motor_update u_update (
      .cmd_i    (cmd),
      .state_i  (state_q[m]),
      .travel_i (travel_q[m]),
      .state_o  (state_d[m]),
      .resp_o   (motor_resp[m])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        state_q[m].status   <= msp_pkg::ST_HALTED;
        state_q[m].load     <= msp_pkg::LOAD_IDLE;
        state_q[m].position <= msp_pkg::reset_position(m);
        state_q[m].target   <= msp_pkg::reset_position(m);
      end else if (req_valid_q) begin
        state_q[m] <= state_d[m];
      end
    end
  end

  // Response code and the addressed motor's state after the request.
  always_comb begin
    res_d.status   = msp_pkg::ST_HALTED;
    res_d.load     = msp_pkg::LOAD_IDLE;
    res_d.position = '0;
    res_d.target   = '0;
    if (idx_valid) begin
      res_d = state_d[idx_q[msp_pkg::MSEL_W-1:0]];
    end
    if (op_q == msp_pkg::OP_TICK) begin
      resp_d = msp_pkg::RESP_OK;
    end else if (!idx_valid) begin
      resp_d = msp_pkg::RESP_NO_MOTOR;
    end else begin
      resp_d = motor_resp[idx_q[msp_pkg::MSEL_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      resp_q <= resp_d;
      res_q  <= res_d;
    end
  end

  assign done_o           = done_q;
  assign response_o       = resp_q;
  assign motor_status_o   = res_q.status;
  assign motor_load_o     = res_q.load;
  assign motor_position_o = res_q.position;
  assign motor_target_o   = res_q.target;

endmodule

// ===== rtl/core/msp_motor_update.sv =====
// Next-state logic of one motor: tick stepping, halt, sync, moves and the
// guarded move checks. Uses types and constants from msp_pkg.
module msp_motor_update (
  input  msp_pkg::motor_cmd_t                    cmd_i,
  input  msp_pkg::motor_state_t                  state_i,
  input  logic [msp_pkg::TRAVEL_W-1:0]           travel_i,
  output msp_pkg::motor_state_t                  state_o,
  output msp_pkg::resp_e                         resp_o
);

  logic                          at_target;
  logic                          up;
  logic signed [msp_pkg::POS_W:0] pos_ext;
  logic signed [msp_pkg::POS_W:0] tgt_ext;
  logic [msp_pkg::POS_W:0]       gap;
  logic                          reaches;
  logic [msp_pkg::POS_W-1:0]     step_ext;
  logic [msp_pkg::POS_W-1:0]     stepped;
  logic                          out_of_range;

  // Distance to the target and direction, taken before the motor moves.
  assign pos_ext   = {state_i.position[msp_pkg::POS_W-1], state_i.position};
  assign tgt_ext   = {state_i.target[msp_pkg::POS_W-1], state_i.target};
  assign at_target = (state_i.position == state_i.target);
  assign up        = (tgt_ext > pos_ext);
  assign gap       = up ? 33'(tgt_ext - pos_ext) : 33'(pos_ext - tgt_ext);
  assign step_ext  = msp_pkg::POS_W'(cmd_i.step);
  assign reaches   = ({1'b0, step_ext} >= gap);
  assign stepped   = up ? (state_i.position + step_ext) : (state_i.position - step_ext);

  // A guarded target must lie in 0..travel.
  assign out_of_range = cmd_i.value[msp_pkg::POS_W-1] ||
                        (cmd_i.value[msp_pkg::POS_W-2:0] > travel_i);

  always_comb begin
    state_o = state_i;
    resp_o  = msp_pkg::RESP_OK;
    if (cmd_i.op == msp_pkg::OP_TICK) begin
      // Every motor steps on a tick; arrival shows as halted on the next one.
      if (at_target) begin
        state_o.status = msp_pkg::ST_HALTED;
        state_o.load   = msp_pkg::LOAD_IDLE;
      end else begin
        state_o.status   = up ? msp_pkg::ST_UP : msp_pkg::ST_DOWN;
        state_o.load     = msp_pkg::LOAD_MOVING;
        state_o.position = reaches ? state_i.target : stepped;
      end
    end else if (cmd_i.addressed) begin
      unique case (cmd_i.op)
        msp_pkg::OP_HALT: begin
          state_o.target = state_i.position;
        end
        msp_pkg::OP_SYNC: begin
          state_o.position = cmd_i.value;
          state_o.target   = cmd_i.value;
        end
        msp_pkg::OP_RAW_MOVE: begin
          state_o.target = cmd_i.value;
        end
        msp_pkg::OP_GUARDED_MOVE: begin
          if (travel_i == '0) begin
            resp_o = msp_pkg::RESP_NOT_CAL;
          end else if (out_of_range) begin
            resp_o = msp_pkg::RESP_INVALID;
          end else if (state_i.status != msp_pkg::ST_HALTED) begin
            resp_o = msp_pkg::RESP_BUSY;
          end else begin
            state_o.target = cmd_i.value;
          end
        end
        default: begin
          // Undefined codes leave the motor alone.
          state_o = state_i;
        end
      endcase
    end
  end

endmodule

// ===== dv/multi_motor_step_positioner_test.sv =====
// Self-checking testbench for the multi-motor step positioner: directed and
// random requests, config changes between phases, every result checked field by
// field. Depends on msp_pkg and multi_motor_step_positioner.
module multi_motor_step_positioner_test;
  import msp_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RUN_LIMIT     = 300000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PRINT_CAP     = 100;

  // Operation codes with no defined behavior, and a register index with no register.
  localparam logic [OP_W-1:0]      OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0]      OP_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 3'd4;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [INDEX_W-1:0]      motor;
    logic signed [POS_W-1:0] value;
    logic [ELAPSED_W-1:0]    elapsed;
    bit                      hold;
  } request_t;

  typedef struct {
    resp_e                   resp;
    status_e                 status;
    logic [LOAD_W-1:0]       load;
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] target;
  } motor_reply_t;

  logic                          clk_i             = 1'b0;
  logic                          rst_ni            = 1'b0;
  logic                          start_i           = 1'b0;
  logic                          busy_o;
  logic [OP_W-1:0]               operation_i       = '0;
  logic [INDEX_W-1:0]            motor_index_i     = '0;
  logic signed [POS_W-1:0]       target_position_i = '0;
  logic [ELAPSED_W-1:0]          elapsed_ms_i      = '0;
  logic                          cfg_valid_i       = 1'b0;
  logic                          cfg_ready_o;
  logic [CFG_IDX_W-1:0]          cfg_index_i       = '0;
  logic [CFG_DATA_W-1:0]         cfg_data_i        = '0;
  logic                          done_o;
  logic [2:0]                    response_o;
  logic [1:0]                    motor_status_o;
  logic [LOAD_W-1:0]             motor_load_o;
  logic signed [POS_W-1:0]       motor_position_o;
  logic signed [POS_W-1:0]       motor_target_o;

  // Predicted motor state and configuration.
  logic [RATE_W-1:0]       pred_rate;
  logic [TRAVEL_W-1:0]     pred_travel [TRAVEL_COUNT];
  logic signed [POS_W-1:0] pred_pos    [MOTOR_COUNT];
  logic signed [POS_W-1:0] pred_tgt    [MOTOR_COUNT];
  status_e                 pred_status [MOTOR_COUNT];
  logic [LOAD_W-1:0]       pred_load   [MOTOR_COUNT];

  // Travels as last written, so that stimulus can aim inside them.
  logic [TRAVEL_W-1:0]     travel_plan [TRAVEL_COUNT];

  request_t     pending_requests [$];
  motor_reply_t expected_replies [$];
  int           in_flight       = 0;
  int           sender_idle_pct = 0;
  int           error_count     = 0;
  int unsigned  cycle_count     = 0;

  multi_motor_step_positioner dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .operation_i       (operation_i),
    .motor_index_i     (motor_index_i),
    .target_position_i (target_position_i),
    .elapsed_ms_i      (elapsed_ms_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .done_o            (done_o),
    .response_o        (response_o),
    .motor_status_o    (motor_status_o),
    .motor_load_o      (motor_load_o),
    .motor_position_o  (motor_position_o),
    .motor_target_o    (motor_target_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("multi_motor_step_positioner_test: errors");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= PRINT_CAP) $display("%0t: mismatch: %s", $time, what);
  endtask

  // Power-up state of the motors and registers.
  function automatic void reset_predictor();
    pred_rate      = 8'd2;
    pred_travel[0] = 31'd40000;
    pred_travel[1] = 31'd12000;
    pred_travel[2] = 31'd40000;
    pred_pos[0]    = 32'sd20000;
    pred_pos[1]    = 32'sd0;
    pred_pos[2]    = 32'sd20000;
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      pred_tgt[m]    = pred_pos[m];
      pred_status[m] = ST_HALTED;
      pred_load[m]   = '0;
    end
  endfunction

  function automatic void write_predictor_reg(logic [CFG_IDX_W-1:0] idx,
                                              logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_STEPS_PER_MS: pred_rate      = data[RATE_W-1:0];
      CFG_TRAVEL0:      pred_travel[0] = data[TRAVEL_W-1:0];
      CFG_TRAVEL1:      pred_travel[1] = data[TRAVEL_W-1:0];
      CFG_TRAVEL2:      pred_travel[2] = data[TRAVEL_W-1:0];
      default:          ;
    endcase
  endfunction

  // One motor's share of a tick: status is taken before the move, and the
  // motor lands exactly on the target when the step reaches it.
  function automatic void advance_motor(int m, logic [STEP_W-1:0] step);
    longint p;
    longint t;
    longint remaining;
    p = pred_pos[m];
    t = pred_tgt[m];
    if (p == t) begin
      pred_load[m]   = '0;
      pred_status[m] = ST_HALTED;
      return;
    end
    pred_load[m]   = 6'd35;
    pred_status[m] = (t > p) ? ST_UP : ST_DOWN;
    remaining = (t > p) ? t - p : p - t;
    if (longint'(step) >= remaining) p = t;
    else if (t > p) p = p + longint'(step);
    else p = p - longint'(step);
    pred_pos[m] = p[POS_W-1:0];
  endfunction

  // Works out the result of one request and updates the predicted state.
  function automatic motor_reply_t apply_request(logic [OP_W-1:0] op,
                                                 logic [INDEX_W-1:0] idx,
                                                 logic signed [POS_W-1:0] value,
                                                 logic [ELAPSED_W-1:0] elapsed);
    motor_reply_t     rep;
    logic [STEP_W-1:0] step;
    bit               known;
    longint           v;
    known    = idx < MOTOR_COUNT;
    rep.resp = RESP_OK;
    v        = value;
    if (op == OP_TICK) begin
      step = elapsed * pred_rate;
      for (int m = 0; m < MOTOR_COUNT; m++) advance_motor(m, step);
    end else if (!known) begin
      rep.resp = RESP_NO_MOTOR;
    end else if (op == OP_HALT) begin
      pred_tgt[idx] = pred_pos[idx];
    end else if (op == OP_SYNC) begin
      pred_pos[idx] = value;
      pred_tgt[idx] = value;
    end else if (op == OP_RAW_MOVE) begin
      pred_tgt[idx] = value;
    end else if (op == OP_GUARDED_MOVE) begin
      // Checks run in order: calibration, range, then motion.
      if (pred_travel[idx] == '0) rep.resp = RESP_NOT_CAL;
      else if (v < 0 || v > longint'(pred_travel[idx])) rep.resp = RESP_INVALID;
      else if (pred_status[idx] != ST_HALTED) rep.resp = RESP_BUSY;
      else pred_tgt[idx] = value;
    end
    if (known) begin
      rep.status   = pred_status[idx];
      rep.load     = pred_load[idx];
      rep.position = pred_pos[idx];
      rep.target   = pred_tgt[idx];
    end else begin
      rep.status   = ST_HALTED;
      rep.load     = '0;
      rep.position = '0;
      rep.target   = '0;
    end
    return rep;
  endfunction

  task automatic check_reply();
    motor_reply_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch("result with no request waiting");
      return;
    end
    want = expected_replies.pop_front();
    if (response_o !== want.resp)
      report_mismatch($sformatf("response %0d, want %0d", response_o, want.resp));
    if (motor_status_o !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", motor_status_o, want.status));
    if (motor_load_o !== want.load)
      report_mismatch($sformatf("load %0d, want %0d", motor_load_o, want.load));
    if (motor_position_o !== want.position)
      report_mismatch($sformatf("position %0d, want %0d", motor_position_o,
                                want.position));
    if (motor_target_o !== want.target)
      report_mismatch($sformatf("target %0d, want %0d", motor_target_o, want.target));
  endtask

  // Monitor: checks results, then follows config writes and accepted requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_predictor();
      expected_replies.delete();
    end else begin
      if (done_o === 1'b1) check_reply();
      if (cfg_valid_i && cfg_ready_o === 1'b1) write_predictor_reg(cfg_index_i, cfg_data_i);
      if (start_i && busy_o === 1'b0)
        expected_replies = {expected_replies,
                            apply_request(operation_i, motor_index_i,
                                          target_position_i, elapsed_ms_i)};
    end
  end

  // Driver: presents the next pending request once the previous one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i           <= 1'b0;
      operation_i       <= '0;
      motor_index_i     <= '0;
      target_position_i <= '0;
      elapsed_ms_i      <= '0;
      in_flight = 0;
    end else begin
      if (start_i && busy_o === 1'b0) in_flight++;
      if (done_o === 1'b1) in_flight--;
      if (!start_i || busy_o === 1'b0) begin
        if (pending_requests.size() != 0
            && $urandom_range(0, 99) >= sender_idle_pct
            && !(pending_requests[0].hold && in_flight > 0)) begin
          start_i           <= 1'b1;
          operation_i       <= pending_requests[0].op;
          motor_index_i     <= pending_requests[0].motor;
          target_position_i <= pending_requests[0].value;
          elapsed_ms_i      <= pending_requests[0].elapsed;
          pending_requests.delete(0);
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  task automatic add_request(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                             logic signed [POS_W-1:0] value,
                             logic [ELAPSED_W-1:0] elapsed, bit hold);
    request_t r;
    r.op      = op;
    r.motor   = idx;
    r.value   = value;
    r.elapsed = elapsed;
    r.hold    = hold;
    pending_requests = {pending_requests, r};
  endtask

  // Waits until every request is answered and the block has settled.
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || start_i || in_flight > 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_TRAVEL0: travel_plan[0] = data[TRAVEL_W-1:0];
      CFG_TRAVEL1: travel_plan[1] = data[TRAVEL_W-1:0];
      CFG_TRAVEL2: travel_plan[2] = data[TRAVEL_W-1:0];
      default:     ;
    endcase
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Target for a guarded move: mostly inside the travel, sometimes just outside.
  function automatic logic signed [POS_W-1:0] pick_target(int m);
    logic [TRAVEL_W-1:0] tr;
    tr = travel_plan[m];
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return {1'b0, tr};
      2:       return -1;
      3:       return {1'b0, tr} + 1;
      default: return $urandom_range(0, tr);
    endcase
  endfunction

  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return ELAPSED_W'($urandom);
      default: return ELAPSED_W'($urandom_range(1, 400));
    endcase
  endfunction

  // Random traffic: mostly a guarded move followed by ticks that carry the
  // motor toward its target, plus syncs, raw moves and unconstrained noise.
  task automatic queue_traffic(int count);
    int made;
    int kind;
    int m;
    int ticks;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 99);
      m    = $urandom_range(0, MOTOR_COUNT - 1);
      if (kind < 70) begin
        add_request(OP_GUARDED_MOVE, m, pick_target(m), ELAPSED_W'($urandom),
                    $urandom_range(0, 49) == 0);
        ticks = $urandom_range(1, 4);
        repeat (ticks)
          add_request(OP_TICK, $urandom_range(0, 7), $urandom, pick_elapsed(), 1'b0);
        made += ticks + 1;
        if ($urandom_range(0, 3) == 0) begin
          add_request(OP_HALT, m, $urandom, ELAPSED_W'($urandom), 1'b0);
          add_request(OP_TICK, m, $urandom, pick_elapsed(), 1'b0);
          made += 2;
        end
      end else if (kind < 80) begin
        add_request(kind < 75 ? OP_SYNC : OP_RAW_MOVE, m, pick_target(m),
                    ELAPSED_W'($urandom), 1'b0);
        made++;
      end else begin
        add_request(OP_W'($urandom_range(0, 7)), $urandom_range(0, 7), $urandom,
                    ELAPSED_W'($urandom), 1'b0);
        made++;
      end
    end
  endtask

  // Directed requests from the power-up state.
  task automatic queue_directed_basics();
    add_request(OP_TICK, 0, 0, 0, 1'b0);
    add_request(OP_GUARDED_MOVE, 0, 40000, 0, 1'b0);
    add_request(OP_GUARDED_MOVE, 1, 0, 0, 1'b0);
    add_request(OP_GUARDED_MOVE, 2, -1, 0, 1'b0);
    add_request(OP_GUARDED_MOVE, 2, 40001, 0, 1'b0);
    add_request(OP_GUARDED_MOVE, 2, 32'h7FFF_FFFF, 0, 1'b0);
    add_request(OP_GUARDED_MOVE, 2, 32'h8000_0000, 0, 1'b0);
    add_request(OP_TICK, 0, 0, 1, 1'b0);
    // Motor 0 is moving now, so a guarded move is refused as busy.
    add_request(OP_GUARDED_MOVE, 0, 100, 0, 1'b0);
    add_request(OP_HALT, 0, 0, 0, 1'b1);
    add_request(OP_TICK, 0, 0, 0, 1'b0);
    add_request(OP_SYNC, 1, 32'h8000_0000, 0, 1'b0);
    add_request(OP_RAW_MOVE, 1, 32'h7FFF_FFFF, 0, 1'b0);
    add_request(OP_TICK, 1, 0, 16'hFFFF, 1'b0);
    add_request(OP_HALT, 1, 0, 0, 1'b0);
    // A step larger than the remaining distance lands on the target.
    add_request(OP_RAW_MOVE, 2, 19999, 0, 1'b0);
    add_request(OP_TICK, 2, 0, 1, 1'b0);
    add_request(OP_TICK, 2, 0, 0, 1'b0);
    // Indexes past the last motor.
    add_request(OP_HALT, 3, 0, 0, 1'b0);
    add_request(OP_SYNC, 7, 32'h1234_5678, 0, 1'b0);
    add_request(OP_GUARDED_MOVE, 5, 10, 0, 1'b0);
    add_request(OP_TICK, 7, 0, 5, 1'b0);
    add_request(OP_SPARE_LO, 0, -5, 9, 1'b0);
    add_request(OP_SPARE_HI, 6, 5, 9, 1'b0);
  endtask

  // Directed requests with the extreme rate, an uncalibrated motor and a
  // travel of one step.
  task automatic queue_directed_limits();
    add_request(OP_HALT, 2, 0, 0, 1'b0);
    add_request(OP_TICK, 2, 0, 0, 1'b0);
    add_request(OP_GUARDED_MOVE, 1, -1, 0, 1'b0);
    add_request(OP_GUARDED_MOVE, 2, 1, 0, 1'b0);
    add_request(OP_GUARDED_MOVE, 2, 2, 0, 1'b0);
    add_request(OP_TICK, 2, 0, 1, 1'b0);
    // Range is checked before motion, so an out-of-range move on a busy motor
    // is invalid rather than busy.
    add_request(OP_GUARDED_MOVE, 2, 5, 0, 1'b0);
    add_request(OP_GUARDED_MOVE, 2, 0, 0, 1'b0);
    add_request(OP_GUARDED_MOVE, 0, 32'h7FFF_FFFF, 0, 1'b0);
  endtask

  // Reset, then phases of traffic with config changes in between.
  initial begin
    travel_plan[0] = 31'd40000;
    travel_plan[1] = 31'd12000;
    travel_plan[2] = 31'd40000;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    queue_directed_basics();
    wait_quiet();

    write_reg(CFG_STEPS_PER_MS, 32'd255);
    write_reg(CFG_TRAVEL0, 32'hFFFF_FFFF);
    write_reg(CFG_TRAVEL1, 32'd0);
    write_reg(CFG_TRAVEL2, 32'd1);
    write_reg(CFG_SPARE, $urandom);
    queue_directed_limits();
    wait_quiet();

    sender_idle_pct = 0;
    queue_traffic(250);
    wait_quiet();

    // A rate of zero leaves moving motors stuck until halted or synced.
    write_reg(CFG_STEPS_PER_MS, 32'd0);
    write_reg(CFG_TRAVEL0, $urandom_range(1, 100000));
    write_reg(CFG_TRAVEL1, $urandom);
    write_reg(CFG_TRAVEL2, $urandom_range(1, 100000));
    sender_idle_pct = 74;
    queue_traffic(100);
    wait_quiet();

    write_reg(CFG_STEPS_PER_MS, $urandom_range(1, 8) | 32'hFFFF_FF00);
    write_reg(CFG_TRAVEL0, 32'd40000);
    write_reg(CFG_TRAVEL1, 32'd12000);
    write_reg(CFG_TRAVEL2, $urandom_range(1, 60000));
    sender_idle_pct = 13;
    queue_traffic(270);
    wait_quiet();

    write_reg(CFG_STEPS_PER_MS, 32'd2);
    write_reg(CFG_TRAVEL2, 32'd40000);
    sender_idle_pct = 74;
    queue_traffic(250);
    wait_quiet();

    if (expected_replies.size() != 0) report_mismatch("results missing at end of run");
    if (error_count == 0) begin
      $display("multi_motor_step_positioner_test: clean");
    end else begin
      $display("multi_motor_step_positioner_test: errors");
    end
    $finish;
  end

endmodule
